// ===== src/ppq_pkg.sv =====
// Package for the priority process queue: shared constants, codes,
// command/response transaction types and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package ppq_pkg;

    // Fixed field widths of the command and response transactions
    localparam int ID_W           = 5;
    localparam int PRIO_FIELD_W   = 8;
    localparam int OCC_W          = 6;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 32;
    localparam int PRIO_WIDTH_DEF = 8;

    // Operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BWD,
        S_INS_WR,
        S_FWD,
        S_HEAD_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [ID_W-1:0]         entry_id;
        logic [PRIO_FIELD_W-1:0] entry_priority;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [ID_W-1:0]         taken_id;
        logic [PRIO_FIELD_W-1:0] taken_priority;
        logic [ID_W-1:0]         head_id;
        logic [PRIO_FIELD_W-1:0] head_priority;
        logic                    head_valid;
        logic [OCC_W-1:0]        occupancy;
    } rsp_t;

endpackage

// ===== src/ppq_slots.sv =====
// Slot storage for the priority process queue: one write port, one read
// port with registered read data. Depends on ppq_pkg.
`timescale 1ns / 1ps

module ppq_slots #(
    parameter int DEPTH      = ppq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = ppq_pkg::PRIO_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [ppq_pkg::ID_W-1:0] wr_id,
    input  logic [PRIO_WIDTH-1:0]    wr_prio,
    input  logic [AW-1:0]            rd_addr,
    output logic [ppq_pkg::ID_W-1:0] rd_id,
    output logic [PRIO_WIDTH-1:0]    rd_prio
);
    import ppq_pkg::*;

    localparam int ROW_W = ID_W + PRIO_WIDTH;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_row_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_id, wr_prio};
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem[rd_addr];
    end

    assign rd_id   = rd_row_reg[ROW_W-1:PRIO_WIDTH];
    assign rd_prio = rd_row_reg[PRIO_WIDTH-1:0];

endmodule

// ===== src/priority_process_queue.sv =====
// Priority process queue, descending priority order, FIFO among equals.
// Inserts move lower-priority entries back from the tail; removals scan from
// the front and close the gap; one slot move per cycle through one write
// port and one read port. Next transaction is accepted the cycle after done.
// Reset (rst_n, async, active low) empties the queue; slot contents are kept.
`timescale 1ns / 1ps

module priority_process_queue #(
    parameter int DEPTH      = ppq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = ppq_pkg::PRIO_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ppq_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output ppq_pkg::rsp_t rsp
);
    import ppq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t                state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            mode_reg, mode_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;
    logic                  found_reg, found_next;
    status_t               status_reg, status_next;
    logic [ID_W-1:0]       tid_reg, tid_next;
    logic [PRIO_WIDTH-1:0] tprio_reg, tprio_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ID_W-1:0]       wr_id;
    logic [PRIO_WIDTH-1:0] wr_prio;
    logic [AW-1:0]         rd_addr;
    logic [ID_W-1:0]       rd_id;
    logic [PRIO_WIDTH-1:0] rd_prio;

    logic                  accept;
    logic                  is_last;
    logic                  is_lower;
    logic                  is_hit;
    logic                  at_full;
    logic                  at_empty;

    ppq_slots #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_prio (wr_prio),
        .rd_addr (rd_addr),
        .rd_id   (rd_id),
        .rd_prio (rd_prio)
    );

    // Handshake and scan conditions
    assign accept   = start && !busy;
    assign at_full  = (count_reg >= CW'(DEPTH));
    assign at_empty = (count_reg == '0);
    assign is_last  = (CW'(idx_reg) == (count_reg - CW'(1)));
    assign is_lower = (rd_prio < prio_reg);
    assign is_hit   = !found_reg &&
                      ((mode_reg == OP_POP) ? (idx_reg == '0) : (rd_id == id_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == OP_INSERT)
                    begin
                        if (at_full)
                            state_next = S_HEAD_RD;
                        else if (at_empty)
                            state_next = S_INS_WR;
                        else
                            state_next = S_BWD;
                    end
                    else if (cmd.mode == OP_POP || cmd.mode == OP_REMOVE)
                    begin
                        state_next = at_empty ? S_HEAD_RD : S_FWD;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
            end
            S_BWD:
            begin
                if (!is_lower)
                    state_next = S_HEAD_RD;
                else if (idx_reg == '0)
                    state_next = S_INS_WR;
            end
            S_INS_WR:  state_next = S_HEAD_RD;
            S_FWD:
            begin
                if (is_last)
                    state_next = S_HEAD_RD;
            end
            S_HEAD_RD: state_next = S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        mode_next   = mode_reg;
        id_next     = id_reg;
        prio_next   = prio_reg;
        found_next  = found_reg;
        status_next = status_reg;
        tid_next    = tid_reg;
        tprio_next  = tprio_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_id       = id_reg;
        wr_prio     = prio_reg;
        rd_addr     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = cmd.mode;
                    id_next     = cmd.entry_id;
                    prio_next   = PRIO_WIDTH'(cmd.entry_priority);
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    tid_next    = '0;
                    tprio_next  = '0;
                    idx_next    = '0;
                    if (cmd.mode == OP_INSERT)
                    begin
                        if (at_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (!at_empty)
                        begin
                            // walk from the tail toward the front
                            rd_addr  = AW'(count_reg - CW'(1));
                            idx_next = AW'(count_reg - CW'(1));
                        end
                    end
                    else if (cmd.mode == OP_POP || cmd.mode == OP_REMOVE)
                    begin
                        if (at_empty)
                            status_next = ST_EMPTY;
                    end
                end
            end
            // Insert: move lower-priority entries back one slot, or insert
            S_BWD:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                if (is_lower)
                begin
                    wr_id    = rd_id;
                    wr_prio  = rd_prio;
                    // stay at the front slot once it has been moved
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - AW'(1);
                        rd_addr  = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            // Insert at the slot in idx_reg
            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                count_next = count_reg + CW'(1);
            end
            // Removal: find the first match, then close the gap
            S_FWD:
            begin
                rd_addr  = idx_reg + AW'(1);
                idx_next = idx_reg + AW'(1);
                if (found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - AW'(1);
                    wr_id   = rd_id;
                    wr_prio = rd_prio;
                end
                else if (is_hit)
                begin
                    found_next = 1'b1;
                    tid_next   = rd_id;
                    tprio_next = rd_prio;
                end
                if (is_last)
                begin
                    if (found_reg || is_hit)
                        count_next = count_reg - CW'(1);
                    else
                        status_next = ST_MISSING;
                end
            end
            S_HEAD_RD: rd_addr = '0;
            S_DONE:    rd_addr = '0;
            default:   rd_addr = '0;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        mode_reg  <= mode_next;
        id_reg    <= id_next;
        prio_reg  <= prio_next;
        tid_reg   <= tid_next;
        tprio_reg <= tprio_next;
    end

    // Response fields
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        rsp.status         = status_reg;
        rsp.taken_id       = tid_reg;
        rsp.taken_priority = PRIO_FIELD_W'(tprio_reg);
        rsp.head_valid     = !at_empty;
        rsp.head_id        = at_empty ? '0 : rd_id;
        rsp.head_priority  = at_empty ? '0 : PRIO_FIELD_W'(rd_prio);
        rsp.occupancy      = OCC_W'(count_reg);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_HEAD_RD))
        else $error("count changed outside the end of an operation");

    a_done_follows_head: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_HEAD_RD))
        else $error("result strobe without head read");

    a_fwd_write_found: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_FWD) |-> found_reg)
        else $error("slot shifted before the removed entry was found");
`endif

endmodule
